// ===== rtl/slcg_pkg.sv =====
// ----------------------------------------------------------------------------
// slcg_pkg: shared constants and word type of the shuffled LCG generator
// Generator constants, output clamp and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package slcg_pkg;

  // Generator word: a residue modulo 2^31-1.
  typedef logic [30:0] word_t;

  // Minimal-standard multiplier and Mersenne modulus.
  localparam logic [14:0] GEN_MUL = 15'd16807;
  localparam word_t       GEN_MOD = 31'h7FFF_FFFF;

  // Largest sample returned (just below one).
  localparam word_t SAMPLE_MAX = 31'd2147483389;

  // Default sizes.
  localparam int TABLE_SIZE_DEF  = 32;
  localparam int NUM_STREAMS_DEF = 4;

endpackage

`default_nettype wire

// ===== rtl/slcg_mulmod.sv =====
// ----------------------------------------------------------------------------
// slcg_mulmod: one step of the multiplicative generator
// Registers x * 16807, then folds the product modulo 2^31-1. The result
// is valid in the cycle after the operand is presented.
// ----------------------------------------------------------------------------
`default_nettype none

module slcg_mulmod (
  input  wire logic           clk,
  input  wire slcg_pkg::word_t x,
  output      slcg_pkg::word_t y
);

  logic [45:0] prod;
  logic [31:0] fold_sum;

  always_ff @(posedge clk) begin
    prod <= 46'(x) * 46'(slcg_pkg::GEN_MUL);
  end

  // 2^31 == 1 mod M: add high part to low part, subtract M once if needed.
  always_comb begin
    fold_sum = 32'(prod[30:0]) + 32'(prod[45:31]);
    if (fold_sum >= 32'(slcg_pkg::GEN_MOD)) begin
      y = 31'(fold_sum - 32'(slcg_pkg::GEN_MOD));
    end else begin
      y = fold_sum[30:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/shuffled_lcg_uniform_generator.sv =====
// ----------------------------------------------------------------------------
// shuffled_lcg_uniform_generator: bank of minimal-standard generators with a
// Bays-Durham shuffle table per stream
// Each request draws from one stream, first (re)building its shuffle table
// when the request asks for a reseed or the stream was never initialized.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | fields
//  --------+-----+-----------------------+----------------------------------
//  request | in  | req_valid / req_ready | mode, stream, seed_value
//  result  | out | rsp_valid / rsp_ready | sample, was_initialized
//
// Draw steps on an initialized stream: accept, state read, multiply, fold
// and slot pick, table read-swap; a build runs generator steps first, one
// multiply and one fold per generator step.
// Reset: clear the sequencer, result valid and per-stream initialized bits;
// no memory sweep, an unmarked stream is rebuilt on its first request.
// Stalls: keep taking requests while a result waits; hold the last step until it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module shuffled_lcg_uniform_generator #(
  parameter int TABLE_SIZE  = slcg_pkg::TABLE_SIZE_DEF,
  parameter int NUM_STREAMS = slcg_pkg::NUM_STREAMS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output      logic        req_ready,
  input  wire logic        mode,
  input  wire logic [1:0]  stream,
  input  wire logic [30:0] seed_value,
  output      logic        rsp_valid,
  input  wire logic        rsp_ready,
  output      logic [30:0] sample,
  output      logic        was_initialized
);

  // Sizes.
  localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int TW = $clog2(TABLE_SIZE);
  localparam int AW = SW + TW;
  localparam int TBL_DEPTH = 1 << AW;
  localparam int CW = $clog2(TABLE_SIZE + 8);

  // Slot pick: j = last / SLOT_DIV, done as an exact reciprocal multiply.
  localparam longint SLOT_DIV   = 1 + (longint'(slcg_pkg::GEN_MOD) - 1) / TABLE_SIZE;
  localparam int     SLOT_SHIFT = 31 + $clog2(SLOT_DIV);
  localparam logic [63:0] SLOT_RECIP64 =
      ((64'd1 << SLOT_SHIFT) + 64'(SLOT_DIV) - 64'd1) / 64'(SLOT_DIV);
  localparam logic [32:0] SLOT_RECIP = SLOT_RECIP64[32:0];

  // Sequencer codes.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDST  = 3'd1;
  localparam logic [2:0] S_IMUL  = 3'd2;
  localparam logic [2:0] S_IFOLD = 3'd3;
  localparam logic [2:0] S_DMUL  = 3'd4;
  localparam logic [2:0] S_DFOLD = 3'd5;
  localparam logic [2:0] S_DRD   = 3'd6;

  logic [2:0]            state;
  logic [NUM_STREAMS-1:0] st_valid;

  logic [SW-1:0]         s_reg;
  logic                  mode_reg;
  slcg_pkg::word_t       seed_reg;
  slcg_pkg::word_t       x_reg;
  slcg_pkg::word_t       last_reg;
  logic [CW-1:0]         cnt;
  logic                  init_flag;
  logic [TW-1:0]         slot_reg;
  logic [63:0]           slot_prod;

  // Stream state memory: {generator state, last_output} per stream.
  logic [61:0]           st_mem [0:NUM_STREAMS-1];
  logic [61:0]           st_q;
  logic                  st_we;

  // Shuffle table memory, one row of 2^TW slots per stream.
  slcg_pkg::word_t       tbl_mem [0:TBL_DEPTH-1];
  slcg_pkg::word_t       tbl_q;
  logic                  tbl_we;
  logic [AW-1:0]         tbl_waddr;
  slcg_pkg::word_t       tbl_wdata;
  logic [AW-1:0]         tbl_raddr;

  logic [6:0]            s_wrap;
  logic [SW-1:0]         s_in;
  slcg_pkg::word_t       seed_in;
  slcg_pkg::word_t       step_y;
  logic                  out_free;
  logic                  need_init;

  slcg_mulmod u_step (
    .clk (clk),
    .x   (x_reg),
    .y   (step_y)
  );

  // Wrap the stream number into range.
  always_comb begin
    s_wrap = {5'd0, stream};
    for (int i = 0; i < 3; i++) begin
      if (s_wrap >= 7'(NUM_STREAMS)) begin
        s_wrap = s_wrap - 7'(NUM_STREAMS);
      end
    end
  end
  assign s_in = s_wrap[SW-1:0];

  // Reseed value: reduce the modulus itself to zero, and zero becomes one.
  assign seed_in = (seed_value == 31'd0 || seed_value == slcg_pkg::GEN_MOD) ?
                   31'd1 : seed_value;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign need_init = mode_reg || !st_valid[s_reg];

  // Finish a draw only when the output register can take the result.
  assign st_we  = (state == S_DRD) && out_free;
  assign tbl_we = ((state == S_IFOLD) && (cnt < CW'(TABLE_SIZE))) || st_we;

  always_comb begin
    if (state == S_IFOLD) begin
      tbl_waddr = {s_reg, cnt[TW-1:0]};
      tbl_wdata = step_y;
    end else begin
      tbl_waddr = {s_reg, slot_reg};
      tbl_wdata = x_reg;
    end
  end

  assign tbl_raddr = {s_reg, slot_prod[SLOT_SHIFT +: TW]};

  // Slot reciprocal multiply; last_reg is stable across the draw multiply.
  always_ff @(posedge clk) begin
    slot_prod <= 64'(last_reg) * 64'(SLOT_RECIP);
  end

  // Memories. Accesses are sequenced, so a read never meets a write to the
  // same entry in flight.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      st_q <= st_mem[s_in];
    end
    if (st_we) begin
      st_mem[s_reg] <= {x_reg, tbl_q};
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DFOLD) begin
      tbl_q <= tbl_mem[tbl_raddr];
    end
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      st_valid  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            s_reg    <= s_in;
            mode_reg <= mode;
            seed_reg <= seed_in;
            state    <= S_RDST;
          end
        end
        S_RDST: begin
          // Rebuild on reseed or first use; otherwise load the saved state.
          init_flag <= need_init;
          if (need_init) begin
            x_reg <= mode_reg ? seed_reg : 31'd1;
            cnt   <= CW'(TABLE_SIZE + 7);
            state <= S_IMUL;
          end else begin
            x_reg    <= st_q[61:31];
            last_reg <= st_q[30:0];
            state    <= S_DMUL;
          end
        end
        S_IMUL: begin
          state <= S_IFOLD;
        end
        S_IFOLD: begin
          // Last value written lands in slot 0 and becomes last_output.
          x_reg    <= step_y;
          last_reg <= step_y;
          if (cnt == '0) begin
            state <= S_DMUL;
          end else begin
            cnt   <= cnt - 1'b1;
            state <= S_IMUL;
          end
        end
        S_DMUL: begin
          state <= S_DFOLD;
        end
        S_DFOLD: begin
          x_reg    <= step_y;
          slot_reg <= slot_prod[SLOT_SHIFT +: TW];
          state    <= S_DRD;
        end
        S_DRD: begin
          // Swap: old slot value goes out, new generator value goes in.
          if (out_free) begin
            rsp_valid       <= 1'b1;
            sample          <= (tbl_q > slcg_pkg::SAMPLE_MAX) ?
                               slcg_pkg::SAMPLE_MAX : tbl_q;
            was_initialized <= init_flag;
            st_valid[s_reg] <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Generator values are never zero, so a zero sample means a stale slot.
  a_sample_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> sample != 31'd0)
    else $error("sample is zero");

  // A reseed always reports an initialization.
  a_reseed_inits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRD && mode_reg) |-> init_flag)
    else $error("reseed finished without initialization");

  // Finishing a draw raises the result and marks the stream initialized.
  a_finish: assert property (@(posedge clk) disable iff (rst)
    st_we |=> rsp_valid && st_valid[$past(s_reg)] && state == S_IDLE)
    else $error("draw finish lost");

  // Table writes stay inside the stream's row.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> tbl_waddr[TW-1:0] < TW'(TABLE_SIZE - 1) ||
               tbl_waddr[TW-1:0] == TW'(TABLE_SIZE - 1))
    else $error("table slot out of range");

endmodule

`default_nettype wire
